FILE: hdl/motor_power_slew_limiter_assert.svh
// Assertion macros shared by the motor power slew limiter RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef MOTOR_POWER_SLEW_LIMITER_ASSERT_SVH
`define MOTOR_POWER_SLEW_LIMITER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MPSL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mpsl assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define MPSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mpsl assertion failed: next-cycle implication");

`endif

FILE: hdl/mpsl_pkg.sv
// Package for the motor power slew limiter: item, state and config types,
// register indexes and fixed constants. No dependencies.
`timescale 1ns / 1ps

package mpsl_pkg;

    // Magnitude of a full-scale power command.
    localparam int FULL_SCALE = 32767;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_POWER_LIMIT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_STEP   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DECEL_STEP   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CUR_THRESH   = 2'd3;

    // Register reset values.
    localparam logic [14:0] POWER_LIMIT_RST = 15'd32767;
    localparam logic [14:0] ACCEL_STEP_RST  = 15'd341;
    localparam logic [14:0] DECEL_STEP_RST  = 15'd68;
    localparam logic [11:0] CUR_THRESH_RST  = 12'd2048;

    // Request types.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_STOP = 1'b1;

    typedef struct packed {
        logic [14:0] power_limit;
        logic [14:0] accel_step;
        logic [14:0] decel_step;
        logic [11:0] current_threshold;
    } t_cfg;

    typedef struct packed {
        logic               req_type;
        logic               new_params;
        logic               brake_req;
        logic [11:0]        current_sample;
        logic signed [16:0] command_power;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] power_level;
        logic               stopped_flag;
        logic               brake_flag;
    } t_state;

    typedef struct packed {
        logic signed [15:0] power_out;
        logic               brake_on;
        logic               stopped;
        logic               over_current;
    } t_out_item;

endpackage

FILE: hdl/mpsl_in_if.sv
// Input channel of the motor power slew limiter: valid/ready plus one request word.
// Depends on nothing beyond the field widths of the block.
`timescale 1ns / 1ps

interface mpsl_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic               new_params;
    logic               brake_req;
    logic [11:0]        current_sample;
    logic signed [16:0] command_power;

    modport source (
        output valid, req_type, new_params, brake_req, current_sample, command_power,
        input  ready
    );
    modport sink (
        input  valid, req_type, new_params, brake_req, current_sample, command_power,
        output ready
    );
endinterface

FILE: hdl/mpsl_out_if.sv
// Output channel of the motor power slew limiter: valid/ready plus one result word.
// Depends on nothing beyond the field widths of the block.
`timescale 1ns / 1ps

interface mpsl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] power_out;
    logic               brake_on;
    logic               stopped;
    logic               over_current;

    modport source (
        output valid, power_out, brake_on, stopped, over_current,
        input  ready
    );
    modport sink (
        input  valid, power_out, brake_on, stopped, over_current,
        output ready
    );
endinterface

FILE: hdl/mpsl_cfg_regs.sv
// Configuration register bank of the motor power slew limiter.
// Depends on mpsl_pkg for the register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module mpsl_cfg_regs
    import mpsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_POWER_LIMIT: n_cfg.power_limit       = i_cfg_data;
                CFG_ACCEL_STEP:  n_cfg.accel_step        = i_cfg_data;
                CFG_DECEL_STEP:  n_cfg.decel_step        = i_cfg_data;
                CFG_CUR_THRESH:  n_cfg.current_threshold = i_cfg_data[11:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_limit       <= POWER_LIMIT_RST;
            r_cfg.accel_step        <= ACCEL_STEP_RST;
            r_cfg.decel_step        <= DECEL_STEP_RST;
            r_cfg.current_threshold <= CUR_THRESH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/mpsl_step.sv
// Combinational step of the motor power slew limiter: next state and result word
// for one request. Depends on mpsl_pkg for the item, state and config types.
`timescale 1ns / 1ps

module mpsl_step
    import mpsl_pkg::*;
(
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    input  t_state    i_state,
    output t_state    o_state,
    output t_out_item o_result
);

    localparam logic signed [17:0] FS_POS = 18'(FULL_SCALE);
    localparam logic signed [17:0] FS_NEG = -18'(FULL_SCALE);

    logic               w_oc_hit;
    logic               w_in_range;
    logic signed [17:0] w_cmd;
    logic signed [17:0] w_power;
    logic signed [17:0] w_target;
    logic signed [17:0] w_up;
    logic signed [17:0] w_down;
    logic signed [17:0] w_lo;
    logic signed [17:0] w_hi;
    logic signed [17:0] w_max;
    logic signed [17:0] w_slewed;
    logic signed [17:0] w_clamped;
    logic               w_oc;
    t_state             w_next;

    assign w_cmd      = 18'(i_item.command_power);
    assign w_power    = 18'(i_state.power_level);
    assign w_in_range = (w_cmd <= FS_POS) && (w_cmd >= FS_NEG);
    assign w_oc_hit   = i_item.current_sample > i_cfg.current_threshold;
    assign w_target   = (i_item.brake_req || !w_in_range) ? 18'sd0 : w_cmd;

    // Acceleration applies away from zero, deceleration toward it.
    assign w_up   = (w_power >= 0) ? $signed({3'b000, i_cfg.accel_step})
                                   : $signed({3'b000, i_cfg.decel_step});
    assign w_down = (w_power >= 0) ? $signed({3'b000, i_cfg.decel_step})
                                   : $signed({3'b000, i_cfg.accel_step});
    assign w_lo   = w_power - w_down;
    assign w_hi   = w_power + w_up;
    assign w_max  = $signed({3'b000, i_cfg.power_limit});

    always_comb begin
        w_slewed = w_target;
        if (w_slewed < w_lo) begin
            w_slewed = w_lo;
        end
        if (w_slewed > w_hi) begin
            w_slewed = w_hi;
        end
        w_clamped = w_slewed;
        if (w_clamped < -w_max) begin
            w_clamped = -w_max;
        end
        if (w_clamped > w_max) begin
            w_clamped = w_max;
        end
    end

    always_comb begin
        w_next = i_state;
        w_oc   = 1'b0;
        priority if (i_item.req_type == REQ_STOP) begin
            w_next.stopped_flag = 1'b1;
            w_next.brake_flag   = 1'b0;
            w_next.power_level  = '0;
        end else if (i_state.stopped_flag) begin
            if (i_item.new_params) begin
                w_next.power_level  = '0;
                w_next.stopped_flag = 1'b0;
            end
        end else if (w_oc_hit) begin
            w_oc = 1'b1;
        end else begin
            w_next.brake_flag  = i_item.brake_req;
            w_next.power_level = w_clamped[15:0];
        end
    end

    assign o_state               = w_next;
    assign o_result.power_out    = w_next.power_level;
    assign o_result.brake_on     = w_next.brake_flag;
    assign o_result.stopped      = w_next.stopped_flag;
    assign o_result.over_current = w_oc;

endmodule

FILE: hdl/motor_power_slew_limiter.sv
// Top level of the motor power slew limiter: input register, step logic, result register.
// Depends on mpsl_pkg, mpsl_in_if, mpsl_out_if, mpsl_cfg_regs, mpsl_step and the assert macros.
`timescale 1ns / 1ps

// Usage notes.
// Each word on the input channel is one control tick or one stop request; every
// word produces exactly one result word on the output channel, in order. A result
// carries the applied drive power, the brake and stopped flags, and an over-current
// flag for that tick.
// An accepted word sits in the input register until the result register can take
// a new result; the step logic then computes the new power and flags and loads
// them into the result register. The step logic is one add/compare/clamp pass, so
// the block sustains one word per cycle while the receiver takes every result.
// When the receiver stalls, the result stays in the result register and one more
// word may still be taken into the input register; ready drops only when both
// registers are full and the result is not taken.
// Configuration registers are written through the plain write port; the user must
// write them only while the block is idle; the block does not enforce it. Reset
// (synchronous, active low) empties both registers, loads the register defaults and
// stops the block at zero power; a control tick with new parameters restarts it.

`include "motor_power_slew_limiter_assert.svh"

module motor_power_slew_limiter
    import mpsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mpsl_in_if.sink               i_in,
    mpsl_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      w_cfg;
    t_in_item  w_in_item;
    t_state    w_step_state;
    t_out_item w_step_result;
    logic      w_advance;
    logic      w_fire;

    // Input register, result register and the controller state.
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_state    r_state;
    t_state    n_state;

    mpsl_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    mpsl_step u_step (
        .i_cfg    (w_cfg),
        .i_item   (r_in_item),
        .i_state  (r_state),
        .o_state  (w_step_state),
        .o_result (w_step_result)
    );

    assign w_in_item.req_type       = i_in.req_type;
    assign w_in_item.new_params     = i_in.new_params;
    assign w_in_item.brake_req      = i_in.brake_req;
    assign w_in_item.current_sample = i_in.current_sample;
    assign w_in_item.command_power  = i_in.command_power;

    // The result register can take a new result when it is empty or being drained.
    assign w_advance = !r_out_valid || o_out.ready;
    assign w_fire    = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;
    assign n_state   = w_fire ? w_step_state : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_state.power_level  <= '0;
            r_state.stopped_flag <= 1'b1;
            r_state.brake_flag   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= w_in_item;
        end
        if (w_fire) begin
            r_out_item <= w_step_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.power_out    = r_out_item.power_out;
    assign o_out.brake_on     = r_out_item.brake_on;
    assign o_out.stopped      = r_out_item.stopped;
    assign o_out.over_current = r_out_item.over_current;

    // The clamp to max power never lets the power reach the most negative code.
    `MPSL_ASSERT_SAME(a_power_not_min, i_clk, i_rst_n, o_out.valid, o_out.power_out != -16'sd32768)

    // A stopped block always reports zero power with brake and over-current clear.
    `MPSL_ASSERT_SAME(a_stopped_idle, i_clk, i_rst_n, o_out.valid && o_out.stopped, (o_out.power_out == 16'sd0) && !o_out.brake_on && !o_out.over_current)

    // An over-current tick leaves the power and the brake flag untouched.
    `MPSL_ASSERT_NEXT(a_oc_holds_state, i_clk, i_rst_n, w_fire && w_step_result.over_current, $stable(r_state.power_level) && $stable(r_state.brake_flag))

    // A word held in the input register is not lost while the result side stalls.
    `MPSL_ASSERT_NEXT(a_in_word_held, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid && $stable(r_in_item))

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for motor_power_slew_limiter: directed and random control words,
// checked against an in-bench model of the power ramp. Needs mpsl_pkg, both channel interfaces
// and the block itself.

module tb;
    import mpsl_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 9;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 322;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 2;
    localparam int TAIL_CYCLES  = 8;

    // Model of the ramp: holds its own copy of the registers and the drive state, and keeps
    // the predicted result word of every accepted request word in arrival order.
    class slew_scoreboard;
        int power_limit;
        int accel_step;
        int decel_step;
        int cur_thresh;
        int power;
        bit stopped;
        bit brake;
        int mismatches;
        t_out_item predicted_drive[$];

        function new();
            power_limit = int'(POWER_LIMIT_RST);
            accel_step  = int'(ACCEL_STEP_RST);
            decel_step  = int'(DECEL_STEP_RST);
            cur_thresh  = int'(CUR_THRESH_RST);
            power       = 0;
            stopped     = 1'b1;
            brake       = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_POWER_LIMIT: power_limit = int'(data);
                CFG_ACCEL_STEP:  accel_step  = int'(data);
                CFG_DECEL_STEP:  decel_step  = int'(data);
                CFG_CUR_THRESH:  cur_thresh  = int'(data[11:0]);
            endcase
        endfunction

        function int clamp(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // Advances the drive state by one request word and queues the result it must give.
        function void take_request(t_in_item w);
            int        cmd;
            int        target;
            int        up_step;
            int        down_step;
            bit        oc;
            t_out_item res;
            cmd = int'($signed(w.command_power));
            oc  = 1'b0;
            if (w.req_type == REQ_STOP) begin
                stopped = 1'b1;
                brake   = 1'b0;
                power   = 0;
            end else if (stopped) begin
                // A stopped block only wakes up; the control law waits for the next tick.
                if (w.new_params) begin
                    power   = 0;
                    stopped = 1'b0;
                end
            end else if (int'(w.current_sample) > cur_thresh) begin
                oc = 1'b1;
            end else begin
                brake = w.brake_req;
                if (w.brake_req || cmd > FULL_SCALE || cmd < -FULL_SCALE) begin
                    target = 0;
                end else begin
                    target = cmd;
                end
                // Acceleration applies away from zero, deceleration toward it.
                if (power >= 0) begin
                    up_step   = accel_step;
                    down_step = decel_step;
                end else begin
                    up_step   = decel_step;
                    down_step = accel_step;
                end
                power = clamp(clamp(target, power - down_step, power + up_step),
                              -power_limit, power_limit);
            end
            res.power_out    = power[15:0];
            res.brake_on     = brake;
            res.stopped      = stopped;
            res.over_current = oc;
            predicted_drive.push_back(res);
        endfunction

        task flag_mismatch(string what, int got, int want);
            mismatches++;
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_drive(t_out_item got);
            t_out_item want;
            if (predicted_drive.size() == 0) begin
                flag_mismatch("result word with none expected", int'(got.power_out), 0);
            end else begin
                want = predicted_drive.pop_front();
                if (got.power_out !== want.power_out) begin
                    flag_mismatch("power_out", int'(got.power_out), int'(want.power_out));
                end
                if (got.brake_on !== want.brake_on) begin
                    flag_mismatch("brake_on", int'(got.brake_on), int'(want.brake_on));
                end
                if (got.stopped !== want.stopped) begin
                    flag_mismatch("stopped", int'(got.stopped), int'(want.stopped));
                end
                if (got.over_current !== want.over_current) begin
                    flag_mismatch("over_current", int'(got.over_current),
                                  int'(want.over_current));
                end
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    mpsl_in_if  in_if();
    mpsl_out_if out_if();

    slew_scoreboard sb;

    // Idle rates in percent for the sender and the receiver, and the length of a forced
    // receiver stall; the receiver process counts the stall down itself.
    int src_idle_pct;
    int snk_idle_pct;
    int rx_hold_left;

    motor_power_slew_limiter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: checks every result word taken at a clock edge, then decides whether to take
    // the next one. A pending forced stall overrides the random choice.
    initial begin
        t_out_item got;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.power_out    = out_if.power_out;
                got.brake_on     = out_if.brake_on;
                got.stopped      = out_if.stopped;
                got.over_current = out_if.over_current;
                sb.check_drive(got);
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Offers one request word, idling first at the current sender rate. Returns at the edge
    // where the block took the word, at which point the model advances.
    task automatic send_word(t_in_item w);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.req_type       <= w.req_type;
        in_if.new_params     <= w.new_params;
        in_if.brake_req      <= w.brake_req;
        in_if.current_sample <= w.current_sample;
        in_if.command_power  <= w.command_power;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        sb.take_request(w);
    endtask

    // Stops offering words and waits until every predicted result word has come back.
    task automatic wait_idle(int extra);
        in_if.valid <= 1'b0;
        while (sb.predicted_drive.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        sb.set_reg(addr, data);
        @(posedge i_clk);
    endtask

    // Writes all four registers back to back; the enable drops only after the last one.
    task automatic program_regs(t_cfg c);
        write_reg(CFG_POWER_LIMIT, c.power_limit);
        write_reg(CFG_ACCEL_STEP, c.accel_step);
        write_reg(CFG_DECEL_STEP, c.decel_step);
        write_reg(CFG_CUR_THRESH, CFG_DATA_W'(c.current_threshold));
        cfg_we <= 1'b0;
    endtask

    function automatic t_in_item req_word(logic req, logic newp, logic brk,
                                          int cur, int cmd);
        t_in_item w;
        w.req_type       = req;
        w.new_params     = newp;
        w.brake_req      = brk;
        w.current_sample = cur[11:0];
        w.command_power  = cmd[16:0];
        return w;
    endfunction

    // Register settings per phase: the reset values first, then both extremes, random moderate
    // steps, a set whose power limit likely sits below the power already reached, and full random.
    function automatic t_cfg phase_regs(int phase);
        t_cfg c;
        case (phase)
            1: begin
                c.power_limit       = 15'd32767;
                c.accel_step        = 15'd32767;
                c.decel_step        = 15'd32767;
                c.current_threshold = 12'd4095;
            end
            2: begin
                c.power_limit       = '0;
                c.accel_step        = '0;
                c.decel_step        = '0;
                c.current_threshold = '0;
            end
            3: begin
                c.power_limit       = 15'($urandom_range(32767));
                c.accel_step        = 15'($urandom_range(2000));
                c.decel_step        = 15'($urandom_range(2000));
                c.current_threshold = 12'($urandom_range(4095, 1024));
            end
            4: begin
                c.power_limit       = 15'd1200;
                c.accel_step        = 15'd4000;
                c.decel_step        = 15'd150;
                c.current_threshold = 12'd3000;
            end
            default: begin
                c.power_limit       = 15'($urandom_range(32767));
                c.accel_step        = 15'($urandom_range(32767));
                c.decel_step        = 15'($urandom_range(32767));
                c.current_threshold = 12'($urandom_range(4095));
            end
        endcase
        return c;
    endfunction

    // Random request word. Most are running ticks with a current under the threshold and
    // an in-range command, so the ramp keeps moving; stops, brakes, over-current and
    // out-of-range commands are mixed in, and some fields get fully random bits.
    function automatic t_in_item random_word();
        t_in_item w;
        int       pick;
        w.req_type   = ($urandom_range(99) < 3) ? REQ_STOP : REQ_TICK;
        w.new_params = ($urandom_range(99) < 20);
        w.brake_req  = ($urandom_range(99) < 10);
        if ($urandom_range(99) < 85) begin
            w.current_sample = 12'($urandom_range(sb.cur_thresh, 0));
        end else begin
            w.current_sample = 12'($urandom_range(4095, 0));
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            w.command_power = 17'(int'($urandom_range(2 * FULL_SCALE)) - FULL_SCALE);
        end else if (pick < 85) begin
            case ($urandom_range(5))
                0:       w.command_power = 17'(FULL_SCALE);
                1:       w.command_power = 17'(-FULL_SCALE);
                2:       w.command_power = 17'(FULL_SCALE + 1);
                3:       w.command_power = 17'(-FULL_SCALE - 1);
                4:       w.command_power = 17'sh0FFFF;
                default: w.command_power = 17'sh10000;
            endcase
        end else begin
            w.command_power = 17'($urandom());
        end
        return w;
    endfunction

    // Short directed walk under the reset settings: ticks and stops while stopped, the
    // restart, ramping up, current exactly at and just over the threshold, commands just
    // beyond full scale and at the field extremes, braking, a zero crossing from positive to
    // negative, and a stop with every other field set.
    task automatic run_directed();
        t_in_item walk[$];
        int       n;
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 0, 1000));
        walk.push_back(req_word(REQ_STOP, 1'b0, 1'b0, 0, 0));
        walk.push_back(req_word(REQ_TICK, 1'b1, 1'b1, 0, 32767));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 0, 32767));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 2048, 32767));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 2049, 32767));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b1, 4095, 0));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 0, 32768));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 0, -65536));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 0, 65535));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 0, -32768));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b1, 0, -32767));
        walk.push_back(req_word(REQ_TICK, 1'b1, 1'b0, 0, -32767));
        for (n = 0; n < 6; n++) begin
            walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 100, -32767));
        end
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 0, 32767));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 4095, -1));
        walk.push_back(req_word(REQ_STOP, 1'b1, 1'b1, 4095, -65536));
        walk.push_back(req_word(REQ_TICK, 1'b1, 1'b1, 0, 32767));
        walk.push_back(req_word(REQ_TICK, 1'b0, 1'b0, 0, 0));
        foreach (walk[i]) send_word(walk[i]);
    endtask

    // Main sequence: reset, the directed walk, then six random phases, each under its own
    // register setting. The idle rates change every two phases; the last two phases run
    // without idling, and the first of them starts with a long receiver stall so that the
    // block fills up and holds off its input.
    initial begin
        int phase;
        int n;
        sb = new();
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_addr             <= '0;
        cfg_data             <= '0;
        in_if.valid          <= 1'b0;
        in_if.req_type       <= REQ_TICK;
        in_if.new_params     <= 1'b0;
        in_if.brake_req      <= 1'b0;
        in_if.current_sample <= '0;
        in_if.command_power  <= '0;
        src_idle_pct = 17;
        snk_idle_pct = 64;
        rx_hold_left = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase / 2)
                0: begin
                    src_idle_pct = 17;
                    snk_idle_pct = 64;
                end
                1: begin
                    src_idle_pct = 64;
                    snk_idle_pct = 17;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            // Registers change only with no word in flight.
            wait_idle(SETTLE);
            if (phase > 0) begin
                program_regs(phase_regs(phase));
            end
            if (phase == 4) begin
                rx_hold_left = HOLD_CYCLES;
            end
            for (n = 0; n < PHASE_WORDS; n++) begin
                send_word(random_word());
            end
        end

        wait_idle(TAIL_CYCLES);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
